### rtl/tsd_pkg.sv
package tsd_pkg;

  localparam int unsigned SpadBytes  = 9;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [IdxW-1:0] IDX_TEMP_LO = 4'd0;
  localparam logic [IdxW-1:0] IDX_TEMP_HI = 4'd1;
  localparam logic [IdxW-1:0] IDX_ALM_HI  = 4'd2;
  localparam logic [IdxW-1:0] IDX_ALM_LO  = 4'd3;
  localparam logic [IdxW-1:0] IDX_CONFIG  = 4'd4;
  localparam logic [IdxW-1:0] IDX_CRC     = 4'd8;

  localparam logic [7:0]  CRC_POLY   = 8'h8C;
  localparam logic [15:0] READING_INIT = 16'hFFFF;

  localparam logic [2:0] ADDR_NOTIFY = 3'd0;

  typedef struct packed {
    logic [7:0]      data;
    logic [IdxW-1:0] idx;
  } tsd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsd_qstat_t;

  typedef struct packed {
    logic              changed;
    logic [1:0]        resolution_code;
    logic signed [7:0] alarm_low;
    logic signed [7:0] alarm_high;
    logic signed [11:0] temperature_q4;
    logic [15:0]       raw_reading;
    logic              status;
  } tsd_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // fraction bits kept for each resolution code
  function automatic logic [3:0] frac_mask(input logic [1:0] res);
    logic [3:0] m;
    unique case (res)
      2'd0: m = 4'b1000;
      2'd1: m = 4'b1100;
      2'd2: m = 4'b1110;
      2'd3: m = 4'b1111;
      default: m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

### rtl/tsd_front.sv
module tsd_front import tsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  input  tsd_qstat_t qstat,
  output logic       in_ready,
  output logic       push,
  output tsd_entry_t push_entry
);

  logic [IdxW-1:0] byte_index;
  logic [IdxW-1:0] byte_index_next;
  logic [IdxW-1:0] idx;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    idx = in_start ? '0 : byte_index;
    if (idx >= IdxW'(SpadBytes)) idx = '0;
    if (idx == IDX_CRC) byte_index_next = '0;
    else                byte_index_next = idx + 1'b1;
  end

  assign push_entry.data = in_byte;
  assign push_entry.idx  = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (push) begin
      byte_index <= byte_index_next;
    end
  end

endmodule

### rtl/tsd_queue.sv
module tsd_queue import tsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tsd_entry_t push_entry,
  input  logic       pop,
  output tsd_entry_t pop_entry,
  output tsd_qstat_t qstat
);

  tsd_entry_t           mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign qstat.full  = (count == QueueCntW'(QueueDepth));
  assign qstat.empty = (count == '0);
  assign pop_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/tsd_back.sv
module tsd_back import tsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        notify_enable,
  input  tsd_qstat_t  qstat,
  input  tsd_entry_t  pop_entry,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output tsd_result_t out_word
);

  logic [7:0]  crc_acc;
  logic [7:0]  temp_low_byte;
  logic [7:0]  temp_high_byte;
  logic [7:0]  high_limit_byte;
  logic [7:0]  low_limit_byte;
  logic [7:0]  config_byte;
  logic [15:0] last_good_reading;

  logic        is_crc;
  logic        good;
  logic [15:0] raw;
  logic [1:0]  res;
  tsd_result_t result_next;

  assign pop    = !qstat.empty && (!out_valid || out_ready);
  assign is_crc = (pop_entry.idx == IDX_CRC);

  always_comb begin
    good = (crc_acc == pop_entry.data);
    raw  = {temp_high_byte, temp_low_byte};
    res  = config_byte[6:5];
    result_next.status          = !good;
    result_next.raw_reading     = raw;
    result_next.temperature_q4  = {raw[11:4], raw[3:0] & frac_mask(res)};
    result_next.alarm_high      = high_limit_byte;
    result_next.alarm_low       = low_limit_byte;
    result_next.resolution_code = res;
    result_next.changed         = good && notify_enable && (raw != last_good_reading);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc           <= '0;
      temp_low_byte     <= '0;
      temp_high_byte    <= '0;
      high_limit_byte   <= '0;
      low_limit_byte    <= '0;
      config_byte       <= '0;
      last_good_reading <= READING_INIT;
    end else if (pop) begin
      if (!is_crc) begin
        // byte 0 restarts the crc from zero
        crc_acc <= crc8_byte((pop_entry.idx == IDX_TEMP_LO) ? 8'h00 : crc_acc,
                             pop_entry.data);
      end else if (good) begin
        last_good_reading <= raw;
      end
      priority case (pop_entry.idx)
        IDX_TEMP_LO: temp_low_byte   <= pop_entry.data;
        IDX_TEMP_HI: temp_high_byte  <= pop_entry.data;
        IDX_ALM_HI:  high_limit_byte <= pop_entry.data;
        IDX_ALM_LO:  low_limit_byte  <= pop_entry.data;
        IDX_CONFIG:  config_byte     <= pop_entry.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_crc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_crc) out_word <= result_next;
  end

endmodule

### rtl/thermometer_scratchpad_decoder.sv
// thermometer scratchpad decoder
// input stream: one scratchpad byte per word on s_tdata, s_tuser[0] set on
// byte 0 to resync the frame; without it the count wraps after nine bytes.
// output stream: one result word per frame, issued after the ninth (crc) byte,
// carrying crc status, raw reading, q8.4 temperature, alarm bytes,
// resolution code and the change flag.
// apb port: register 0 bit 0 is notify_enable; pready is always high.
// throughput: one byte per cycle while the queue has room; the crc folds in a full byte at each pop.
// the crc byte passes through the byte queue and then the output register
// before the result word is valid.
// a four-entry byte queue separates the index front end from the crc and
// capture back end, so input keeps flowing while a result waits.
// if m_tready stays low the result holds, the back end stops, and s_tready
// drops once the queue fills.
// reset clears the byte count, crc, captured bytes and notify_enable, sets
// the last good reading to 0xffff and empties the queue and output register.
module thermometer_scratchpad_decoder import tsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, raw_reading, temperature_q4, alarm_high, alarm_low,
  // resolution_code, changed
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        notify_enable;
  logic        push;
  logic        pop;
  tsd_entry_t  push_entry;
  tsd_entry_t  pop_entry;
  tsd_qstat_t  qstat;
  tsd_result_t out_word;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_NOTIFY[2]) ? {31'b0, notify_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      notify_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_NOTIFY[2]) begin
      notify_enable <= pwdata[0];
    end
  end

  tsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_start   (s_tuser[0]),
    .qstat      (qstat),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  tsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  tsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .notify_enable (notify_enable),
    .qstat         (qstat),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_word      (out_word)
  );

  assign m_tdata = out_word;

endmodule

### rtl/tsd_checker.sv
module tsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // a result word is never shown right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // crc mismatch never reports a change
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[47])
    else $error("change flag on bad frame");

  // 9-bit resolution keeps only the half-degree fraction bit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[46:45] == 2'd0 |-> m_tdata[19:17] == 3'd0)
    else $error("fraction not masked");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[28:21] == m_tdata[12:5])
    else $error("integer part does not match raw reading");

endmodule

bind thermometer_scratchpad_decoder tsd_checker u_tsd_checker (.*);
